>>> hdl/fcmc_pkg.sv
package fcmc_pkg;

  localparam int DEPTH    = 128;
  localparam int KEY_BITS = 10;
  localparam int CAP_W    = 8;
  localparam int CNT_W    = 16;

  // match bits are folded in groups before the final OR
  localparam int GROUP    = 16;
  localparam int NGROUPS  = (DEPTH + GROUP - 1) / GROUP;

  localparam logic [CNT_W-1:0] MISS_MAX = {CNT_W{1'b1}};
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CAP_W-1:0]    cap_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;    // register the match bit
    logic shift;  // take the neighbor's entry
    key_t key;    // key under lookup
  } cell_ctrl_t;

endpackage

>>> hdl/fcmc_if.sv
interface fcmc_in_if;
  logic           valid;
  logic           ready;
  fcmc_pkg::key_t word_key;

  modport source (output valid, output word_key, input ready);
  modport sink   (input valid, input word_key, output ready);
endinterface

interface fcmc_out_if;
  logic           valid;
  logic           ready;
  logic           hit;
  fcmc_pkg::cnt_t miss_count;

  modport source (output valid, output hit, output miss_count, input ready);
  modport sink   (input valid, input hit, input miss_count, output ready);
endinterface

interface fcmc_cfg_if;
  logic           valid;
  logic           ready;
  fcmc_pkg::cap_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/fcmc_cell.sv
module fcmc_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcmc_pkg::cell_ctrl_t ctrl,
  input  logic                 in_win,
  input  fcmc_pkg::key_t       prev_key,
  input  logic                 prev_valid,
  output fcmc_pkg::key_t       key_o,
  output logic                 valid_o,
  output logic                 match_o
);

  fcmc_pkg::key_t key_r;
  logic           valid_r;
  logic           match_r;

  // hold the entry unless a miss pushes the chain one step older
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= prev_valid & in_win;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key_r <= prev_key;
    end
    if (ctrl.cmp) begin
      match_r <= valid_r & in_win & (key_r == ctrl.key);
    end
  end

  assign key_o   = key_r;
  assign valid_o = valid_r;
  assign match_o = match_r;

endmodule

>>> hdl/fcmc_or_tree.sv
module fcmc_or_tree (
  input  logic                          clk,
  input  logic                          load,
  input  logic [fcmc_pkg::DEPTH-1:0]    match,
  output logic [fcmc_pkg::NGROUPS-1:0]  grp_o
);

  logic [fcmc_pkg::NGROUPS-1:0] grp_r;
  logic [fcmc_pkg::NGROUPS-1:0] grp_nxt;

  always_comb begin
    for (int g = 0; g < fcmc_pkg::NGROUPS; g++) begin
      grp_nxt[g] = 1'b0;
      for (int j = 0; j < fcmc_pkg::GROUP; j++) begin
        if (g * fcmc_pkg::GROUP + j < fcmc_pkg::DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | match[g * fcmc_pkg::GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_nxt;
    end
  end

  assign grp_o = grp_r;

endmodule

>>> hdl/fifo_cache_miss_counter_top.sv
// Fully associative key store with first-in-first-out replacement and a
// saturating miss counter.
// in_ch  : lookup requests, one word_key each (valid/ready).
// out_ch : one result per request: hit and the running miss_count.
// cfg_ch : capacity register (reset 128, values above the built depth act
//          as the depth, zero stores nothing). Write only while idle.
// The entries live in a row of cells, newest in cell 0. A miss shifts the
// whole row one cell older and drops anything past the capacity.
// Flow: a request is compared in the cells (ST_CMP), the match bits are
// folded in groups of 16 (ST_RED) and the hit is resolved and the row
// updated (ST_DEC), where the result is written to the output register
// and a new request can be taken in that same cycle. No request is
// taken before the last one is resolved; the compare/fold/update loop
// through the cell row sets this.
// Reset empties the store, clears the miss count and sets capacity 128;
// no clearing pass is needed. If the receiver stalls, a result waits in
// the output register; the next request still runs its compare and fold
// and then holds until the pending result is taken.
module fifo_cache_miss_counter_top (
  input  logic       clk,
  input  logic       rst_n,
  fcmc_in_if.sink    in_ch,
  fcmc_out_if.source out_ch,
  fcmc_cfg_if.sink   cfg_ch
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_RED  = 4'b0100,
    ST_DEC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  fcmc_pkg::key_t key_r;
  fcmc_pkg::cap_t cap_r;
  fcmc_pkg::cnt_t miss_r, miss_nxt;
  logic           out_valid_r;
  logic           out_hit_r;
  fcmc_pkg::cnt_t out_cnt_r;

  fcmc_pkg::cell_ctrl_t          ctrl;
  fcmc_pkg::key_t                cell_key   [fcmc_pkg::DEPTH];
  logic [fcmc_pkg::DEPTH-1:0]    cell_valid;
  logic [fcmc_pkg::DEPTH-1:0]    cell_match;
  logic [fcmc_pkg::DEPTH-1:0]    in_win;
  logic [fcmc_pkg::NGROUPS-1:0]  grp;

  logic in_fire, go, dec_fire, hit, shift;

  // config register: always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= fcmc_pkg::CAP_RESET;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.data;
    end
  end

  // resolve stage may only finish when the output register is free
  assign hit      = |grp;
  assign go       = !out_valid_r || out_ch.ready;
  assign dec_fire = (state_r == ST_DEC) && go;
  assign shift    = dec_fire && !hit && (cap_r != '0);

  assign in_ch.ready = (state_r == ST_IDLE) || dec_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_DEC;
      ST_DEC: begin
        if (dec_fire) begin
          state_nxt = in_fire ? ST_CMP : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r <= in_ch.word_key;
    end
  end

  // saturating miss count
  always_comb begin
    miss_nxt = miss_r;
    if (dec_fire && !hit && (miss_r != fcmc_pkg::MISS_MAX)) begin
      miss_nxt = miss_r + fcmc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      miss_r <= miss_nxt;
      if (dec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec_fire) begin
      out_hit_r <= hit;
      out_cnt_r <= miss_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.miss_count = out_cnt_r;

  // broadcast control to the cell row
  assign ctrl.cmp   = (state_r == ST_CMP);
  assign ctrl.shift = shift;
  assign ctrl.key   = key_r;

  // cell 0 takes the new key; cell i takes cell i-1
  for (genvar i = 0; i < fcmc_pkg::DEPTH; i++) begin : g_cell
    assign in_win[i] = (32'(i) < 32'(cap_r));

    if (i == 0) begin : g_head
      fcmc_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_win     (in_win[i]),
        .prev_key   (key_r),
        .prev_valid (1'b1),
        .key_o      (cell_key[i]),
        .valid_o    (cell_valid[i]),
        .match_o    (cell_match[i])
      );
    end else begin : g_body
      fcmc_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_win     (in_win[i]),
        .prev_key   (cell_key[i-1]),
        .prev_valid (cell_valid[i-1]),
        .key_o      (cell_key[i]),
        .valid_o    (cell_valid[i]),
        .match_o    (cell_match[i])
      );
    end
  end

  fcmc_or_tree u_or_tree (
    .clk   (clk),
    .load  (state_r == ST_RED),
    .match (cell_match),
    .grp_o (grp)
  );

  // a pending result blocks the resolve stage
  a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC && out_valid_r && !out_ch.ready) |=> (state_r == ST_DEC))
    else $error("resolve stage advanced over a pending result");

  // requests are taken only when the cell row is free
  a_ready_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == ST_IDLE || state_r == ST_DEC))
    else $error("request taken while compare in flight");

  // a stored miss lands in the newest cell
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    shift |=> cell_valid[0])
    else $error("newest cell not valid after append");

  // the count never steps back
  a_miss_mono: assert property (@(posedge clk) disable iff (!rst_n)
    dec_fire |=> (miss_r >= $past(miss_r)))
    else $error("miss count decreased");

endmodule

>>> verif/fifo_cache_miss_counter_top_tb.sv
`timescale 1ns / 1ps

module fifo_cache_miss_counter_top_tb;

  // Generous cycle limit: about 560 requests with idle bursts on both sides,
  // plus one long receiver hold-off.
  localparam int unsigned CYCLE_LIMIT = 200_000;
  // Stop printing mismatch lines after this many, but keep counting.
  localparam int unsigned PRINT_LIMIT = 100;

  typedef struct packed {
    logic           hit;
    fcmc_pkg::cnt_t miss_count;
  } lookup_result_t;

  // Shadow of the key store: entries oldest first, a saturating miss count and
  // the capacity register. Keep the queue of results still owed by the block.
  class lookup_scoreboard;
    fcmc_pkg::key_t held_keys[fcmc_pkg::DEPTH];
    int unsigned    fill;
    fcmc_pkg::cnt_t miss_total;
    fcmc_pkg::cap_t capacity;
    lookup_result_t owed_results[$];
    int unsigned    mismatches;

    function new();
      fill       = 0;
      miss_total = '0;
      capacity   = fcmc_pkg::CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(fcmc_pkg::cap_t value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Look the key up among the newest entries the capacity allows, then
    // apply the replacement on a miss.
    function void note_request(fcmc_pkg::key_t key);
      int unsigned    span;
      int unsigned    window;
      int unsigned    keep;
      logic           found;
      lookup_result_t res;
      span   = (capacity > fcmc_pkg::DEPTH) ? fcmc_pkg::DEPTH : capacity;
      window = (fill < span) ? fill : span;
      found  = 1'b0;
      for (int unsigned i = fill - window; i < fill; i++) begin
        if (held_keys[i] == key) found = 1'b1;
      end
      if (!found) begin
        if (miss_total != fcmc_pkg::MISS_MAX) miss_total = miss_total + 1'b1;
        if (span > 0) begin
          // drop the oldest entries so that capacity remain after the append
          keep = span - 1;
          if (keep > fill) keep = fill;
          for (int unsigned i = 0; i < keep; i++) held_keys[i] = held_keys[fill - keep + i];
          fill = keep;
          if (fill < fcmc_pkg::DEPTH) begin
            held_keys[fill] = key;
            fill++;
          end
        end
      end
      res.hit        = found;
      res.miss_count = miss_total;
      owed_results   = {owed_results, res};
    endfunction

    task report_mismatch(string what);
      if (mismatches < PRINT_LIMIT) $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_result(logic hit, fcmc_pkg::cnt_t count);
      lookup_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result with no request owed: hit=%0b miss_count=%0d",
                                  hit, count));
        return;
      end
      want = owed_results[0];
      owed_results.delete(0);
      if (hit !== want.hit)
        report_mismatch($sformatf("hit: got %0b, want %0b", hit, want.hit));
      if (count !== want.miss_count)
        report_mismatch($sformatf("miss_count: got %0d, want %0d", count, want.miss_count));
    endtask
  endclass

  logic clk;
  logic rst_n;

  fcmc_in_if  in_ch ();
  fcmc_out_if out_ch ();
  fcmc_cfg_if cfg_ch ();

  fifo_cache_miss_counter_top DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  lookup_scoreboard board = new();

  // Idle percentages for each side, set per phase; zero gives a stretch with no gaps.
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  // Set by the main flow to make the receiver hold off this many cycles.
  int unsigned hold_request  = 0;
  int unsigned cycle_count   = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Kill a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check every result taken at this edge against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.hit, out_ch.miss_count);
  end

  // Receiver: take results, stall in random bursts, and serve a long hold-off
  // on request. Each pass starts with one drive of ready and ends on an edge.
  initial begin
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else if ($urandom_range(0, 99) < take_idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request, maybe after an idle burst, and hold it until accepted.
  // Valid stays high into the next request unless a gap is drawn.
  task automatic send_request(input fcmc_pkg::key_t key);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.word_key <= key;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(key);
  endtask

  // Write capacity only once every owed result has come back: each request
  // yields exactly one result, so the block is idle then.
  task automatic write_capacity(input fcmc_pkg::cap_t value);
    while (board.pending() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    board.set_capacity(value);
  endtask

  task automatic send_burst(input fcmc_pkg::cap_t cap_value, input fcmc_pkg::key_t keys[$]);
    write_capacity(cap_value);
    foreach (keys[i]) send_request(keys[i]);
    in_ch.valid <= 1'b0;
  endtask

  // Random phase: mostly keys from a working set a bit larger than the
  // capacity, so hits, evictions and refills all happen; the rest is
  // full-range noise.
  task automatic run_phase(input fcmc_pkg::cap_t cap_value, input int unsigned count,
                           input int unsigned send_pct, input int unsigned take_pct,
                           input int unsigned hold);
    int unsigned    span;
    int unsigned    pool;
    fcmc_pkg::key_t base;
    write_capacity(cap_value);
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
    hold_request  = hold;
    span = (cap_value > fcmc_pkg::DEPTH) ? fcmc_pkg::DEPTH : cap_value;
    pool = span + span / 2 + 2;
    base = fcmc_pkg::key_t'($urandom);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 80)
        send_request(fcmc_pkg::key_t'(base + $urandom_range(0, pool - 1)));
      else
        send_request(fcmc_pkg::key_t'($urandom));
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    fcmc_pkg::key_t keys[$];

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.word_key = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: key extremes, alternating bits, repeat hits.
    send_idle_pct = 30;
    take_idle_pct = 30;
    keys = {10'd0, 10'd1023, 10'd0, 10'd1023, 10'h155, 10'h2AA, 10'h155};
    send_burst(fcmc_pkg::CAP_RESET, keys);
    // Capacity lowered below the fill: only the newest two take part.
    keys = {10'd0, 10'h2AA, 10'd1023, 10'd0};
    send_burst(fcmc_pkg::cap_t'(2), keys);
    // Zero capacity: always a miss, nothing stored.
    keys = {10'd0, 10'd0};
    send_burst(fcmc_pkg::cap_t'(0), keys);
    // Single entry.
    keys = {10'd0, 10'd0, 10'd5};
    send_burst(fcmc_pkg::cap_t'(1), keys);
    // Capacity above the built depth acts as the depth.
    keys = {10'd5, 10'd6, 10'd5};
    send_burst(fcmc_pkg::cap_t'(255), keys);

    // Random phases over a spread of capacities; fill the store first, then
    // cut it down hard. One phase stalls the receiver long enough to back up
    // the block while the sender keeps offering.
    run_phase(fcmc_pkg::cap_t'(128), 60, 25, 25, 0);
    run_phase(fcmc_pkg::cap_t'(3),   50, 40, 10, 0);
    run_phase(fcmc_pkg::cap_t'(255), 50, 0,  0,  0);
    run_phase(fcmc_pkg::cap_t'(16),  50, 0,  30, 80);
    run_phase(fcmc_pkg::cap_t'(0),   40, 20, 20, 0);
    run_phase(fcmc_pkg::cap_t'(1),   50, 50, 50, 0);
    run_phase(fcmc_pkg::cap_t'(64),  50, 10, 40, 0);
    run_phase(fcmc_pkg::cap_t'(200), 50, 30, 0,  0);
    run_phase(fcmc_pkg::cap_t'(8),   50, 0,  0,  0);
    run_phase(fcmc_pkg::cap_t'(4),   50, 35, 35, 0);

    // Last part, no idling: misses only with zero capacity, then hits resume
    // with a small store.
    run_phase(fcmc_pkg::cap_t'(0), 20, 0, 0, 0);
    run_phase(fcmc_pkg::cap_t'(4), 20, 0, 0, 0);

    // Drain, then wait for stray results before checking that none is owed.
    for (int w = 0; w < 2000 && board.pending() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.pending()));

    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/fcmc_pkg.sv
hdl/fcmc_if.sv
hdl/fcmc_cell.sv
hdl/fcmc_or_tree.sv
hdl/fifo_cache_miss_counter_top.sv
verif/fifo_cache_miss_counter_top_tb.sv
